// ===== rtl/core/ibt_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval booking table package
// Shared types, status codes and default sizes for the booking table core.
// ----------------------------------------------------------------------------
package ibt_pkg;

   localparam int IBT_CAPACITY  = 64;
   localparam int IBT_TIME_BITS = 32;

   localparam logic [1:0] STATUS_BOOKED  = 2'd0;
   localparam logic [1:0] STATUS_OVERLAP = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] end_time;
   } ibt_req_type;

   typedef struct packed {
      logic       booked;
      logic [1:0] status;
      logic [6:0] entries_used;
   } ibt_rsp_type;

   typedef struct packed {
      logic check_en;
      logic shift_en;
   } ibt_cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE
   } ibt_state_type;

endpackage

// ===== rtl/core/interval_booking_table_core.sv =====
// ----------------------------------------------------------------------------
// Interval booking table core
// Books half-open time intervals into a chain of cells after an overlap
// check against every stored interval.
// ----------------------------------------------------------------------------
// A new transaction can be started in the cycle the result appears. The
// request is registered, every cell then compares it with its own interval
// and registers a hit bit, and in the decide state the hit bits are
// combined, the status is decided and a booked interval is shifted into the
// head of the cell chain; the result is registered. busy is high while a
// transaction is in progress. The result is driven for exactly one cycle
// with rsp_valid high; the receiver cannot stall it.
module interval_booking_table_core
   import ibt_pkg::*;
#(
   parameter int CAPACITY  = IBT_CAPACITY,
   parameter int TIME_BITS = IBT_TIME_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  ibt_req_type req_data,
   output logic        rsp_valid,
   output ibt_rsp_type rsp_data
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   ibt_state_type        state_ff;
   ibt_state_type        state_in;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic [TIME_BITS-1:0] req_start_ff;
   logic [TIME_BITS-1:0] req_end_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   ibt_rsp_type          rsp_data_ff;
   ibt_rsp_type          rsp_data_in;
   ibt_cell_ctrl_type    cell_ctrl;
   logic                 accept;
   logic                 any_hit;
   logic                 full;

   logic [TIME_BITS-1:0] chain_start [CAPACITY+1];
   logic [TIME_BITS-1:0] chain_end   [CAPACITY+1];
   logic [CAPACITY-1:0]  hits;

   assign chain_start[0] = req_start_ff;
   assign chain_end[0]   = req_end_ff;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      ibt_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .active     (count_ff > CNT_BITS'(k)),
         .req_start  (req_start_ff),
         .req_end    (req_end_ff),
         .prev_start (chain_start[k]),
         .prev_end   (chain_end[k]),
         .next_start (chain_start[k+1]),
         .next_end   (chain_end[k+1]),
         .hit        (hits[k])
      );
   end

   assign accept  = start && !busy;
   assign any_hit = |hits;
   assign full    = count_ff >= CNT_BITS'(CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_start_ff <= TIME_BITS'(req_data.start_time);
         req_end_ff   <= TIME_BITS'(req_data.end_time);
      end
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rsp_valid_in       = 1'b0;
      rsp_data_in        = rsp_data_ff;
      cell_ctrl.check_en = 1'b0;
      cell_ctrl.shift_en = 1'b0;
      busy               = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cell_ctrl.check_en = 1'b1;
            state_in           = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (any_hit) begin
               rsp_data_in.booked = 1'b0;
               rsp_data_in.status = STATUS_OVERLAP;
            end else if (full) begin
               rsp_data_in.booked = 1'b0;
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.booked = 1'b1;
               rsp_data_in.status = STATUS_BOOKED;
               cell_ctrl.shift_en = 1'b1;
               count_in           = count_ff + CNT_BITS'(1);
            end
            rsp_data_in.entries_used = 7'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/ibt_cell.sv =====
// ----------------------------------------------------------------------------
// Interval booking table cell
// Holds one stored interval, checks it against the pending request and
// hands its interval to the next cell when a new booking is inserted.
// ----------------------------------------------------------------------------
module ibt_cell
   import ibt_pkg::*;
#(
   parameter int TIME_BITS = IBT_TIME_BITS
) (
   input  logic                 clock,
   input  ibt_cell_ctrl_type    ctrl,
   input  logic                 active,
   input  logic [TIME_BITS-1:0] req_start,
   input  logic [TIME_BITS-1:0] req_end,
   input  logic [TIME_BITS-1:0] prev_start,
   input  logic [TIME_BITS-1:0] prev_end,
   output logic [TIME_BITS-1:0] next_start,
   output logic [TIME_BITS-1:0] next_end,
   output logic                 hit
);

   logic [TIME_BITS-1:0] start_ff;
   logic [TIME_BITS-1:0] end_ff;
   logic                 hit_ff;
   logic                 hit_in;

   assign hit_in = active && !((end_ff <= req_start) || (start_ff >= req_end));

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         start_ff <= prev_start;
         end_ff   <= prev_end;
      end
      if (ctrl.check_en) begin
         hit_ff <= hit_in;
      end
   end

   assign next_start = start_ff;
   assign next_end   = end_ff;
   assign hit        = hit_ff;

endmodule
